### hdl/kti_pkg.sv
// ----------------------------------------------------------------------------
// kti_pkg
// Shared types and constants for the keyframe track interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package kti_pkg;

    localparam int MAX_ENTITIES  = 64;
    localparam int MAX_KEYFRAMES = 256;
    localparam int ENT_W         = $clog2(MAX_ENTITIES);
    localparam int KF_W          = $clog2(MAX_KEYFRAMES);
    localparam int CNT_W         = KF_W + 1;
    localparam int COMP_W        = 4;
    localparam int KF_ADDR_W     = ENT_W + KF_W + COMP_W;
    localparam int DIV_STEPS     = 16;
    localparam int T_W           = 17;

    localparam logic [COMP_W-1:0] COMP_TS        = 4'd0;
    localparam logic [COMP_W-1:0] COMP_LAST      = 4'd12;
    localparam logic [31:0]       TICK_RESET     = 32'd1092;
    localparam logic [T_W-1:0]    T_ONE          = 17'h10000;
    localparam logic [CNT_W-1:0]  CNT_MAX        = CNT_W'(MAX_KEYFRAMES);

    typedef enum logic [2:0] {
        ACT_WRITE   = 3'd0,
        ACT_SET_CNT = 3'd1,
        ACT_APPEND  = 3'd2,
        ACT_EVAL    = 3'd3,
        ACT_ADVANCE = 3'd4
    } action_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TRACK,
        ST_WALK_RD,
        ST_WALK_CHK,
        ST_IDX_WR,
        ST_TS0_RD,
        ST_TS1_RD,
        ST_GAP,
        ST_DIV,
        ST_BL_A,
        ST_BL_B,
        ST_BL_MUL,
        ST_BL_SUM
    } state_t;

    typedef struct packed {
        logic [2:0]        action;
        logic [ENT_W-1:0]  entity;
        logic [KF_W-1:0]   slot;
        logic [COMP_W-1:0] component;
        logic signed [31:0] value;
        logic [CNT_W-1:0]  count;
    } req_item_t;

    typedef struct packed {
        logic [ENT_W-1:0]   entity_out;
        logic [1:0]         kind;
        logic signed [31:0] x_value;
        logic signed [31:0] y_value;
        logic signed [31:0] z_value;
        logic               last;
    } res_item_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [KF_W-1:0]  index;
    } track_t;

endpackage

`default_nettype wire

### hdl/kti_divider.sv
// ----------------------------------------------------------------------------
// kti_divider
// Restoring divider, one quotient bit per cycle: (dividend << 16) / divisor,
// for dividend < divisor, giving a 16-bit fraction.
// ----------------------------------------------------------------------------
`default_nettype none

module kti_divider (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic [15:0]      quotient
);
    import kti_pkg::*;

    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] div_reg, div_next;
    logic [15:0] q_reg, q_next;
    logic [32:0] shifted;
    logic [32:0] diff;
    logic        ge;

    always_comb
    begin
        shifted   = {rem_reg, 1'b0};
        diff      = shifted - {1'b0, div_reg};
        ge        = (shifted >= {1'b0, div_reg});
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        q_next    = q_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            rem_next = dividend;
            div_next = divisor;
            q_next   = '0;
        end
        else if (run_reg)
        begin
            // remainder stays below the divisor, so 32 bits hold it
            rem_next = ge ? diff[31:0] : shifted[31:0];
            q_next   = {q_reg[14:0], ge};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'(DIV_STEPS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        div_reg <= div_next;
        q_reg   <= q_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

### hdl/keyframe_track_interpolator.sv
// ----------------------------------------------------------------------------
// keyframe_track_interpolator
// Per-entity keyframe tracks in memory, linear blend between keyframes.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken on request when start is high and busy is low.
//   Component writes, set count and advance time finish in the cycle they
//   are taken; busy stays low. Append commit holds busy for 1 cycle.
//   Evaluate reads the track's count and index, walks the index over
//   keyframes already passed (one store read per step), reads both
//   timestamps, runs a bit-serial divide when the elapsed time lies below
//   the gap, then blends 12 components through ST_BL_A, ST_BL_B, ST_BL_MUL
//   and ST_BL_SUM, reading off the single store read port.
//   When the index ends on the final keyframe, the timestamp reads and the
//   divide are skipped. Results leave on result with a one-cycle
//   result_valid strobe, four per evaluation of a non-empty track, kinds
//   0..3, last set on the fourth, which shows in the first idle cycle.
//   The receiver cannot stall; results are not held. The user must write
//   tick_step through cfg_we/cfg_wdata only while idle; nothing enforces it.
//   Reset clears the clock, tick_step to its default and all track
//   counts and indices; keyframe words are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module keyframe_track_interpolator (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire kti_pkg::req_item_t request,
    input  wire logic               cfg_we,
    input  wire logic [31:0]        cfg_wdata,
    output logic                    result_valid,
    output kti_pkg::res_item_t      result
);
    import kti_pkg::*;

    state_t state_reg, state_next;

    logic [31:0]       time_reg, time_next;
    logic [31:0]       tick_reg;
    logic [ENT_W-1:0]  ent_reg, ent_next;
    logic [2:0]        act_reg, act_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [KF_W-1:0]   idx_reg, idx_next;
    logic [KF_W-1:0]   k0_reg, k0_next;
    logic [KF_W-1:0]   k1_reg, k1_next;
    logic [31:0]       ts0_reg, ts0_next;
    logic [T_W-1:0]    t_reg, t_next;
    logic [COMP_W-1:0] w_reg, w_next;
    logic [1:0]        c_reg, c_next;
    logic [1:0]        kind_reg, kind_next;
    logic signed [31:0] a_reg, a_next;
    logic signed [50:0] prod_reg, prod_next;
    logic signed [31:0] x_reg, x_next;
    logic signed [31:0] y_reg, y_next;
    logic               res_valid_reg, res_valid_next;
    res_item_t          res_reg, res_next;

    logic accept;
    assign accept = start && (state_reg == ST_IDLE);

    // keyframe store
    logic [31:0]          kf_mem [2**KF_ADDR_W];
    logic                 kf_we;
    logic [KF_ADDR_W-1:0] kf_waddr, kf_raddr;
    logic [31:0]          kf_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (kf_we)
        begin
            kf_mem[kf_waddr] <= request.value;
        end
        kf_rdata_reg <= kf_mem[kf_raddr];
    end

    // track count and index, valid bit per entity stands for the zero reset
    track_t                 trk_mem [MAX_ENTITIES];
    logic [MAX_ENTITIES-1:0] trk_valid_reg;
    logic                   trk_we;
    logic [ENT_W-1:0]       trk_waddr;
    track_t                 trk_wdata;
    track_t                 trk_rdata_reg;
    logic                   trk_rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (trk_we)
        begin
            trk_mem[trk_waddr] <= trk_wdata;
        end
        trk_rdata_reg <= trk_mem[request.entity];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trk_valid_reg  <= '0;
            trk_rvalid_reg <= 1'b0;
        end
        else
        begin
            trk_rvalid_reg <= trk_valid_reg[request.entity];
            if (trk_we)
            begin
                trk_valid_reg[trk_waddr] <= 1'b1;
            end
        end
    end

    track_t trk_cur;
    assign trk_cur = trk_rvalid_reg ? trk_rdata_reg : '0;

    // divider
    logic [31:0] elapsed, gap;
    logic        div_start, div_done;
    logic [15:0] div_q;

    kti_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (elapsed),
        .divisor  (gap),
        .done     (div_done),
        .quotient (div_q)
    );

    logic [CNT_W-1:0] idx_plus;
    logic [32:0]      time_sum;
    logic signed [32:0] diff;
    logic signed [50:0] rounded;
    logic signed [31:0] blended;

    assign idx_plus = {1'b0, idx_reg} + CNT_W'(1);
    assign elapsed  = (time_reg >= ts0_reg) ? time_reg - ts0_reg : '0;
    assign gap      = (kf_rdata_reg > ts0_reg) ? kf_rdata_reg - ts0_reg : 32'd1;
    assign time_sum = {1'b0, time_reg} + {1'b0, tick_reg};
    assign diff     = {kf_rdata_reg[31], kf_rdata_reg} - {a_reg[31], a_reg};
    assign rounded  = prod_reg + 51'sd32768;
    assign blended  = a_reg + 32'(rounded >>> 16);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (request.action == ACT_APPEND ||
                               request.action == ACT_EVAL))
                begin
                    state_next = ST_TRACK;
                end
            end
            ST_TRACK:
            begin
                if (act_reg == ACT_APPEND || trk_cur.count == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_WALK_RD;
                end
            end
            ST_WALK_RD:  state_next = (idx_plus < n_reg) ? ST_WALK_CHK : ST_IDX_WR;
            ST_WALK_CHK: state_next = (kf_rdata_reg <= time_reg) ? ST_WALK_RD : ST_IDX_WR;
            ST_IDX_WR:   state_next = (idx_plus >= n_reg) ? ST_BL_A : ST_TS0_RD;
            ST_TS0_RD:   state_next = ST_TS1_RD;
            ST_TS1_RD:   state_next = ST_GAP;
            ST_GAP:      state_next = (elapsed >= gap) ? ST_BL_A : ST_DIV;
            ST_DIV:      state_next = div_done ? ST_BL_A : ST_DIV;
            ST_BL_A:     state_next = ST_BL_B;
            ST_BL_B:     state_next = ST_BL_MUL;
            ST_BL_MUL:   state_next = ST_BL_SUM;
            ST_BL_SUM:   state_next = (w_reg == COMP_LAST) ? ST_IDLE : ST_BL_A;
            default:     state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        time_next      = time_reg;
        ent_next       = ent_reg;
        act_next       = act_reg;
        n_next         = n_reg;
        idx_next       = idx_reg;
        k0_next        = k0_reg;
        k1_next        = k1_reg;
        ts0_next       = ts0_reg;
        t_next         = t_reg;
        w_next         = w_reg;
        c_next         = c_reg;
        kind_next      = kind_reg;
        a_next         = a_reg;
        prod_next      = prod_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        res_valid_next = 1'b0;
        res_next       = res_reg;
        kf_we          = 1'b0;
        kf_waddr       = {request.entity, request.slot, request.component};
        kf_raddr       = {ent_reg, idx_reg, COMP_TS};
        trk_we         = 1'b0;
        trk_waddr      = ent_reg;
        trk_wdata      = '0;
        div_start      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ent_next = request.entity;
                    act_next = request.action;
                    case (request.action)
                        ACT_ADVANCE:
                        begin
                            time_next = time_sum[32] ? '1 : time_sum[31:0];
                        end
                        ACT_WRITE:
                        begin
                            kf_we = (request.component <= COMP_LAST);
                        end
                        ACT_SET_CNT:
                        begin
                            trk_we          = 1'b1;
                            trk_waddr       = request.entity;
                            trk_wdata.count = (request.count > CNT_MAX) ? CNT_MAX
                                                                        : request.count;
                            trk_wdata.index = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_TRACK:
            begin
                n_next   = trk_cur.count;
                idx_next = trk_cur.index;
                if (act_reg == ACT_APPEND)
                begin
                    trk_we          = 1'b1;
                    trk_wdata.index = trk_cur.index;
                    trk_wdata.count = (trk_cur.count < CNT_MAX) ? trk_cur.count + CNT_W'(1)
                                                                : trk_cur.count;
                end
            end
            ST_WALK_RD:
            begin
                kf_raddr = {ent_reg, idx_plus[KF_W-1:0], COMP_TS};
            end
            ST_WALK_CHK:
            begin
                if (kf_rdata_reg <= time_reg)
                begin
                    idx_next = idx_plus[KF_W-1:0];
                end
            end
            ST_IDX_WR:
            begin
                trk_we          = 1'b1;
                trk_wdata.count = n_reg;
                trk_wdata.index = idx_reg;
                w_next          = 4'd1;
                c_next          = '0;
                kind_next       = '0;
                if (idx_plus >= n_reg)
                begin
                    // at the final keyframe: hold it
                    k0_next = KF_W'(n_reg - CNT_W'(1));
                    k1_next = KF_W'(n_reg - CNT_W'(1));
                    t_next  = '0;
                end
                else
                begin
                    k0_next = idx_reg;
                    k1_next = idx_plus[KF_W-1:0];
                end
            end
            ST_TS0_RD:
            begin
                kf_raddr = {ent_reg, idx_reg, COMP_TS};
            end
            ST_TS1_RD:
            begin
                ts0_next = kf_rdata_reg;
                kf_raddr = {ent_reg, idx_plus[KF_W-1:0], COMP_TS};
            end
            ST_GAP:
            begin
                if (elapsed >= gap)
                begin
                    t_next = T_ONE;
                end
                else
                begin
                    div_start = 1'b1;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    t_next = {1'b0, div_q};
                end
            end
            ST_BL_A:
            begin
                kf_raddr = {ent_reg, k0_reg, w_reg};
            end
            ST_BL_B:
            begin
                a_next   = kf_rdata_reg;
                kf_raddr = {ent_reg, k1_reg, w_reg};
            end
            ST_BL_MUL:
            begin
                prod_next = 51'(diff * $signed({1'b0, t_reg}));
            end
            ST_BL_SUM:
            begin
                w_next = w_reg + COMP_W'(1);
                case (c_reg)
                    2'd0:    x_next = blended;
                    2'd1:    y_next = blended;
                    default:
                    begin
                        res_valid_next      = 1'b1;
                        res_next.entity_out = ent_reg;
                        res_next.kind       = kind_reg;
                        res_next.x_value    = x_reg;
                        res_next.y_value    = y_reg;
                        res_next.z_value    = blended;
                        res_next.last       = (kind_reg == 2'd3);
                    end
                endcase
                if (c_reg == 2'd2)
                begin
                    c_next    = '0;
                    kind_next = kind_reg + 2'd1;
                end
                else
                begin
                    c_next = c_reg + 2'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            time_reg      <= '0;
            tick_reg      <= TICK_RESET;
            res_valid_reg <= 1'b0;
            t_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            time_reg      <= time_next;
            res_valid_reg <= res_valid_next;
            t_reg         <= t_next;
            if (cfg_we)
            begin
                tick_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg  <= ent_next;
        act_reg  <= act_next;
        n_reg    <= n_next;
        idx_reg  <= idx_next;
        k0_reg   <= k0_next;
        k1_reg   <= k1_next;
        ts0_reg  <= ts0_next;
        w_reg    <= w_next;
        c_reg    <= c_next;
        kind_reg <= kind_next;
        a_reg    <= a_next;
        prod_reg <= prod_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        res_reg  <= res_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe longer than one cycle");

    a_mid_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |-> busy)
        else $error("evaluation ended before its fourth result");

    a_t_range: assert property (@(posedge clk) disable iff (!rst_n)
        t_reg <= T_ONE)
        else $error("blend factor above one");

    a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside its wait state");

endmodule

`default_nettype wire

### tb/keyframe_track_interpolator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyframe_track_interpolator_tb
// Builds keyframe tracks, moves the clock and evaluates entities in directed
// and random order. A local track model predicts the four blended vectors of
// every non-empty evaluation; each result strobe is matched to the oldest one.
// ----------------------------------------------------------------------------
`default_nettype none

module keyframe_track_interpolator_tb;

    import kti_pkg::*;

    localparam int  KF_WORDS   = 13;
    localparam int  TARGET     = 135;
    localparam int  QUIET_FROM = 330;
    localparam int  SETTLE     = 120;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    req_item_t   request;
    logic        cfg_we;
    logic [31:0] cfg_wdata;
    logic        result_valid;
    res_item_t   result;

    // track model
    logic [31:0]      kf_mem [int];
    logic [CNT_W-1:0] trk_cnt [MAX_ENTITIES];
    logic [KF_W-1:0]  trk_idx [MAX_ENTITIES];
    logic [31:0]      now_q;
    logic [31:0]      step_q;

    res_item_t vec_q[$];
    int        errors;
    int        items_sent;
    bit        quiet;

    keyframe_track_interpolator i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .result_valid (result_valid),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int kf_addr(int e, int s, int c);
        return (e * MAX_KEYFRAMES + s) * KF_WORDS + c;
    endfunction

    function automatic logic [31:0] kf_word(int e, int s, int c);
        if (kf_mem.exists(kf_addr(e, s, c)))
            return kf_mem[kf_addr(e, s, c)];
        return 32'd0;
    endfunction

    function automatic bit kf_whole(int e, int s);
        for (int c = 1; c < KF_WORDS; c++)
            if (!kf_mem.exists(kf_addr(e, s, c)))
                return 1'b0;
        return 1'b1;
    endfunction

    // true when evaluating e touches only written keyframe words
    function automatic bit eval_safe(int e);
        int n;
        int i;
        n = trk_cnt[e];
        i = trk_idx[e];
        if (n == 0)
            return 1'b1;
        while (i + 1 < n)
        begin
            if (!kf_mem.exists(kf_addr(e, i + 1, 0)))
                return 1'b0;
            if (kf_mem[kf_addr(e, i + 1, 0)] <= now_q)
                i++;
            else
                break;
        end
        if (i >= n - 1)
            return kf_whole(e, n - 1);
        return kf_mem.exists(kf_addr(e, i, 0)) && kf_whole(e, i) && kf_whole(e, i + 1);
    endfunction

    function automatic logic [31:0] lerp_word(logic [31:0] wa, logic [31:0] wb,
                                              logic [16:0] t);
        longint a;
        longint b;
        longint r;
        a = longint'($signed(wa));
        b = longint'($signed(wb));
        r = a + (((b - a) * longint'(t) + 64'sd32768) >>> 16);
        return r[31:0];
    endfunction

    task automatic track_apply(input req_item_t rq);
        int          e;
        int          n;
        int          i;
        int          k0;
        int          k1;
        logic [16:0] t;
        logic [31:0] ts0;
        logic [31:0] ts1;
        logic [31:0] el;
        logic [31:0] gap;
        logic [32:0] sum;
        logic [31:0] r [3];
        res_item_t   v;
        e = rq.entity;
        case (rq.action)
            ACT_ADVANCE:
            begin
                sum = {1'b0, now_q} + {1'b0, step_q};
                now_q = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            end
            ACT_WRITE:
                if (rq.component <= COMP_LAST)
                    kf_mem[kf_addr(e, rq.slot, rq.component)] = rq.value;
            ACT_SET_CNT:
            begin
                trk_cnt[e] = (rq.count > CNT_MAX) ? CNT_MAX : rq.count;
                trk_idx[e] = '0;
            end
            ACT_APPEND:
                if (trk_cnt[e] < CNT_MAX)
                    trk_cnt[e] = trk_cnt[e] + 1'b1;
            ACT_EVAL:
            begin
                n = trk_cnt[e];
                if (n != 0)
                begin
                    i = trk_idx[e];
                    while (i + 1 < n && kf_word(e, i + 1, 0) <= now_q)
                        i++;
                    trk_idx[e] = KF_W'(i);
                    if (i >= n - 1)
                    begin
                        k0 = n - 1;
                        k1 = n - 1;
                        t  = '0;
                    end
                    else
                    begin
                        ts0 = kf_word(e, i, 0);
                        ts1 = kf_word(e, i + 1, 0);
                        el  = (now_q >= ts0) ? now_q - ts0 : 32'd0;
                        gap = (ts1 > ts0) ? ts1 - ts0 : 32'd1;
                        k0  = i;
                        k1  = i + 1;
                        if (el >= gap)
                            t = T_ONE;
                        else
                            t = 17'(({16'd0, el} << 16) / {16'd0, gap});
                    end
                    for (int k = 0; k < 4; k++)
                    begin
                        for (int c = 0; c < 3; c++)
                            r[c] = lerp_word(kf_word(e, k0, 1 + 3 * k + c),
                                             kf_word(e, k1, 1 + 3 * k + c), t);
                        v.entity_out = ENT_W'(e);
                        v.kind       = 2'(k);
                        v.x_value    = r[0];
                        v.y_value    = r[1];
                        v.z_value    = r[2];
                        v.last       = (k == 3);
                        vec_q.insert(vec_q.size(), v);
                    end
                end
            end
            default:
                ;
        endcase
    endtask

    // called at a rising edge; returns at the edge that took the item
    task automatic send_item(input req_item_t rq);
        int gap;
        bit taken;
        gap = 0;
        if (!quiet && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 19);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= rq;
        do
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
        while (!taken);
        items_sent++;
        if (items_sent >= QUIET_FROM)
            quiet = 1'b1;
        track_apply(rq);
    endtask

    function automatic req_item_t mk_item(action_t act, int e);
        req_item_t rq;
        rq.action    = act;
        rq.entity    = ENT_W'(e);
        rq.slot      = KF_W'($urandom);
        rq.component = COMP_W'($urandom);
        rq.value     = $urandom;
        rq.count     = CNT_W'($urandom);
        return rq;
    endfunction

    task automatic put_word(int e, int s, int c, logic [31:0] w);
        req_item_t rq;
        rq           = mk_item(ACT_WRITE, e);
        rq.slot      = KF_W'(s);
        rq.component = COMP_W'(c);
        rq.value     = w;
        send_item(rq);
    endtask

    // fill: 0 random, 1 most negative, 2 most positive, 3 small random
    task automatic put_keyframe(int e, int s, logic [31:0] ts, int fill);
        logic [31:0] w;
        put_word(e, s, COMP_TS, ts);
        for (int c = 1; c < KF_WORDS; c++)
        begin
            case (fill)
                1:       w = 32'h8000_0000;
                2:       w = 32'h7FFF_FFFF;
                3:       w = 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
                default: w = $urandom;
            endcase
            put_word(e, s, c, w);
        end
    endtask

    task automatic put_simple(action_t act, int e, int cnt);
        req_item_t rq;
        rq       = mk_item(act, e);
        rq.count = CNT_W'(cnt);
        send_item(rq);
    endtask

    task automatic evaluate(int e);
        if (eval_safe(e))
            put_simple(ACT_EVAL, e, 0);
    endtask

    task automatic drain_vectors();
        int guard;
        start <= 1'b0;
        guard = 0;
        while (vec_q.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_tick_step(logic [31:0] v);
        drain_vectors();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        step_q = v;
    endtask

    task automatic test_directed();
        req_item_t rq;
        evaluate(1);                          // empty track, no vectors
        put_keyframe(1, 0, 32'd0, 1);
        put_keyframe(1, 1, 32'h0002_0000, 2);
        put_simple(ACT_SET_CNT, 1, 2);
        evaluate(1);
        repeat (3) put_simple(ACT_ADVANCE, 0, 0);
        evaluate(1);
        rq = mk_item(ACT_WRITE, 1);
        rq.component = 4'd15;                 // out of range, ignored
        send_item(rq);
        rq = mk_item(ACT_EVAL, 1);
        rq.action = 3'd7;                     // reserved action
        send_item(rq);
        evaluate(1);
        // clock still before first timestamp, then a zero-width gap
        put_keyframe(2, 0, 32'h4000_0000, 3);
        put_simple(ACT_SET_CNT, 2, 1);
        evaluate(2);
        put_simple(ACT_APPEND, 2, 0);
        put_keyframe(2, 1, 32'h4000_0000, 0);
        evaluate(2);
        put_simple(ACT_SET_CNT, 3, 300);      // saturates
        put_simple(ACT_APPEND, 3, 0);
        put_simple(ACT_SET_CNT, 3, 0);
        evaluate(3);
    endtask

    task automatic build_track(int e);
        int          n;
        logic [31:0] ts;
        n  = $urandom_range(1, 3);
        ts = now_q + 32'($urandom_range(0, 4000)) - 32'd2000;
        for (int s = 0; s < n; s++)
        begin
            put_keyframe(e, s, ts, ($urandom_range(0, 3) == 0) ? 0 : 3);
            case ($urandom_range(0, 5))
                0:       ts = ts;
                1:       ts = ts - 32'($urandom_range(1, 500));
                default: ts = ts + 32'($urandom_range(1, 6000));
            endcase
        end
        if ($urandom_range(0, 1) == 0 || n == 1)
            put_simple(ACT_SET_CNT, e, n);
        else
        begin
            put_simple(ACT_SET_CNT, e, n - 1);
            put_simple(ACT_APPEND, e, 0);
        end
    endtask

    task automatic test_random();
        req_item_t rq;
        int        e;
        int        pick;
        bit        tick_done;
        tick_done = 1'b0;
        while (items_sent < TARGET)
        begin
            if (!tick_done && items_sent > 100)
            begin
                set_tick_step(32'($urandom_range(200, 4000)));
                tick_done = 1'b1;
            end
            e    = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 7);
            pick = $urandom_range(0, 99);
            if (pick < 12)
                build_track(e);
            else if (pick < 52)
                evaluate(e);
            else if (pick < 80)
                put_simple(ACT_ADVANCE, $urandom_range(0, 63), 0);
            else if (pick < 86)
            begin
                rq = mk_item(ACT_WRITE, e);
                rq.component = COMP_W'($urandom_range(13, 15));
                send_item(rq);
            end
            else if (pick < 91)
            begin
                rq = mk_item(ACT_EVAL, e);
                rq.action = 3'($urandom_range(5, 7));
                send_item(rq);
            end
            else if (pick < 96)
                send_item(mk_item(ACT_WRITE, $urandom_range(8, 63)));
            else
                put_simple(($urandom_range(0, 1) == 0) ? ACT_APPEND : ACT_SET_CNT,
                           $urandom_range(0, 63), $urandom_range(0, 511));
        end
    endtask

    task automatic test_tick_extremes();
        set_tick_step(32'd0);
        put_simple(ACT_ADVANCE, 0, 0);
        evaluate(1);
        set_tick_step(32'hFFFF_FFFF);
        put_simple(ACT_ADVANCE, 0, 0);
        put_simple(ACT_ADVANCE, 0, 0);        // clock saturates
        evaluate(2);
        // full-length track, walk runs to the last keyframe
        for (int s = 0; s < MAX_KEYFRAMES; s++)
            put_word(62, s, COMP_TS, 32'(s * 16));
        put_keyframe(62, MAX_KEYFRAMES - 1, 32'hFFFF_FFFF, 0);
        put_simple(ACT_SET_CNT, 62, 300);
        put_simple(ACT_APPEND, 62, 0);
        evaluate(62);
        set_tick_step(TICK_RESET);
    endtask

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        request    = '0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        errors     = 0;
        items_sent = 0;
        quiet      = 1'b0;
        now_q      = '0;
        step_q     = TICK_RESET;
        for (int e = 0; e < MAX_ENTITIES; e++)
        begin
            trk_cnt[e] = '0;
            trk_idx[e] = '0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random();
        test_tick_extremes();
        drain_vectors();
        if (vec_q.size() != 0)
        begin
            $error("%0d vectors never arrived", vec_q.size());
            errors++;
        end
        if (errors == 0)
            $display("PASS keyframe_track_interpolator");
        else
            $display("FAIL keyframe_track_interpolator");
        $finish;
    end

    // results are stable from edge to edge, so look at them mid-cycle
    always @(negedge clk)
    begin
        res_item_t want;
        if (rst_n && result_valid)
        begin
            if (vec_q.size() == 0)
            begin
                $error("unexpected result entity %0d kind %0d",
                       result.entity_out, result.kind);
                errors++;
            end
            else
            begin
                want = vec_q.pop_front();
                if (result.entity_out !== want.entity_out)
                begin
                    $error("entity_out: expected %0d, got %0d",
                           want.entity_out, result.entity_out);
                    errors++;
                end
                if (result.kind !== want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, result.kind);
                    errors++;
                end
                if (result.x_value !== want.x_value)
                begin
                    $error("x_value: expected %h, got %h", want.x_value, result.x_value);
                    errors++;
                end
                if (result.y_value !== want.y_value)
                begin
                    $error("y_value: expected %h, got %h", want.y_value, result.y_value);
                    errors++;
                end
                if (result.z_value !== want.z_value)
                begin
                    $error("z_value: expected %h, got %h", want.z_value, result.z_value);
                    errors++;
                end
                if (result.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, result.last);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("FAIL keyframe_track_interpolator");
        $finish;
    end

endmodule

`default_nettype wire
